// File: hdl/lpoe_pkg.sv
// Shared types, constants and element mapping for the lattice path orbit enumerator.
package lpoe_pkg;

    localparam int MAX_LEN_DEF   = 16;
    localparam int MAX_PATHS_DEF = 385;

    localparam int TI_W   = 9;
    localparam int PIDX_W = 9;

    localparam logic [TI_W-1:0] FULL_COUNT    = 9'd384;
    localparam logic [TI_W-1:0] SPATIAL_COUNT = 9'd48;

    localparam logic [1:0] PERM4 [24][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd3, 2'd1, 2'd0, 2'd2},
        '{2'd3, 2'd1, 2'd2, 2'd0}, '{2'd3, 2'd2, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    localparam logic [1:0] PERM3 [6][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd1, 2'd0, 2'd2, 2'd3},
        '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_CHK_LOAD,
        ST_CHK_WAIT,
        ST_CHK_CMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic do_load;
        logic put_done;
        logic k_clr;
        logic k_inc;
        logic gen;
        logic ti_inc;
        logic j_clr;
        logic j_inc;
        logic rd;
        logic cmp;
        logic emit;
        logic fc_inc;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic fc_full;
        logic fc_zero;
        logic ti_end;
        logic k_last;
        logic j_last;
        logic hit;
    } t_status;

    // Image of one direction under transform t of the selected group.
    function automatic logic signed [3:0] map_elem(logic signed [3:0] e, logic mode,
                                                   logic [TI_W-1:0] t);
        logic [3:0] mag;
        logic [1:0] a;
        logic [1:0] p;
        logic       neg;
        logic [4:0] pi4;
        logic [2:0] pi3;
        logic [3:0] r;
        mag = e[3] ? 4'(-e) : 4'(e);
        a   = 2'(mag - 4'd1);
        pi4 = 5'(t >> 4);
        pi3 = 3'(t >> 3);
        if (mode == 1'b0) begin
            p   = PERM4[pi4][a];
            neg = t[2'd3 - a];
        end else begin
            p   = PERM3[pi3][a];
            neg = (a == 2'd3) ? 1'b0 : t[2'd2 - a];
        end
        r = {2'b00, p} + 4'd1;
        if (e == 4'sd0) begin
            map_elem = 4'sd0;
        end else if (neg ^ e[3]) begin
            map_elem = 4'(-r);
        end else begin
            map_elem = 4'(r);
        end
    endfunction

endpackage

// File: hdl/lpoe_ctrl.sv
// Controller state machine sequencing generation, comparison and emission.
module lpoe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_func,
    input  lpoe_pkg::t_status   i_status,
    output lpoe_pkg::t_cmd      o_cmd,
    output logic                busy
);

    lpoe_pkg::t_state r_state, n_state;
    logic             w_req_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpoe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A request that can produce nothing answers done straight from idle.
    assign w_req_done = i_status.len_zero || i_status.fc_full ||
                        (!i_status.fc_zero && i_status.ti_end);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpoe_pkg::ST_IDLE: begin
                if (start && i_func && !w_req_done) begin
                    n_state = lpoe_pkg::ST_GEN;
                end
            end
            lpoe_pkg::ST_GEN: begin
                if (i_status.k_last) begin
                    n_state = i_status.fc_zero ? lpoe_pkg::ST_EMIT : lpoe_pkg::ST_CHK_LOAD;
                end
            end
            lpoe_pkg::ST_CHK_LOAD: begin
                if (i_status.k_last) begin
                    n_state = lpoe_pkg::ST_CHK_WAIT;
                end
            end
            lpoe_pkg::ST_CHK_WAIT: begin
                n_state = lpoe_pkg::ST_CHK_CMP;
            end
            lpoe_pkg::ST_CHK_CMP: begin
                if (i_status.hit) begin
                    n_state = i_status.ti_end ? lpoe_pkg::ST_IDLE : lpoe_pkg::ST_GEN;
                end else if (i_status.k_last) begin
                    n_state = i_status.j_last ? lpoe_pkg::ST_EMIT : lpoe_pkg::ST_CHK_LOAD;
                end
            end
            lpoe_pkg::ST_EMIT: begin
                if (i_status.k_last) begin
                    n_state = lpoe_pkg::ST_IDLE;
                end
            end
            default: n_state = lpoe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            lpoe_pkg::ST_IDLE: begin
                o_cmd.do_load  = start && !i_func;
                o_cmd.put_done = start && i_func && w_req_done;
                o_cmd.k_clr    = 1'b1;
            end
            lpoe_pkg::ST_GEN: begin
                o_cmd.gen   = 1'b1;
                o_cmd.k_inc = 1'b1;
                if (i_status.k_last) begin
                    o_cmd.k_clr  = 1'b1;
                    o_cmd.ti_inc = !i_status.fc_zero;
                    o_cmd.j_clr  = 1'b1;
                end
            end
            lpoe_pkg::ST_CHK_LOAD: begin
                o_cmd.rd    = 1'b1;
                o_cmd.k_inc = 1'b1;
                o_cmd.k_clr = i_status.k_last;
            end
            lpoe_pkg::ST_CHK_WAIT: begin
                o_cmd.k_clr = 1'b1;
            end
            lpoe_pkg::ST_CHK_CMP: begin
                o_cmd.cmp   = 1'b1;
                o_cmd.k_inc = 1'b1;
                if (i_status.hit) begin
                    o_cmd.k_clr    = 1'b1;
                    o_cmd.put_done = i_status.ti_end;
                end else if (i_status.k_last) begin
                    o_cmd.k_clr = 1'b1;
                    o_cmd.j_inc = !i_status.j_last;
                end
            end
            lpoe_pkg::ST_EMIT: begin
                o_cmd.emit  = 1'b1;
                o_cmd.k_inc = 1'b1;
                if (i_status.k_last) begin
                    o_cmd.k_clr  = 1'b1;
                    o_cmd.fc_inc = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != lpoe_pkg::ST_IDLE);

endmodule

// File: hdl/lpoe_dp.sv
// Datapath: path registers, candidate builder, found-path memory and comparator.
module lpoe_dp #(
    parameter int MAX_LEN   = lpoe_pkg::MAX_LEN_DEF,
    parameter int MAX_PATHS = lpoe_pkg::MAX_PATHS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_group_mode,
    input  logic signed [3:0]           i_elem,
    input  logic                        i_last,
    input  lpoe_pkg::t_cmd              i_cmd,
    output lpoe_pkg::t_status           o_status,
    output logic                        o_strobe,
    output logic signed [3:0]           o_out_elem,
    output logic                        o_last_elem,
    output logic                        o_done_res,
    output logic [lpoe_pkg::PIDX_W-1:0] o_path_index
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int ROW_W = $clog2(MAX_PATHS);
    localparam int FC_W  = $clog2(MAX_PATHS + 1);
    localparam int MEM_D = MAX_PATHS << IDX_W;

    logic                       r_mode;
    logic signed [3:0]          r_base  [MAX_LEN];
    logic signed [3:0]          r_cand  [MAX_LEN];
    logic signed [3:0]          r_rcand [MAX_LEN];
    logic signed [3:0]          r_a     [MAX_LEN];
    logic [LEN_W-1:0]           r_len;
    logic                       r_fresh;
    logic [FC_W-1:0]            r_fc;
    logic [lpoe_pkg::TI_W-1:0]  r_ti;
    logic [IDX_W-1:0]           r_k;
    logic [ROW_W-1:0]           r_j;
    logic signed [3:0]          r_mem [MEM_D];
    logic signed [3:0]          r_rdata;
    logic                       r_rd_vld;
    logic [IDX_W-1:0]           r_rd_idx;

    logic signed [3:0]          w_sat;
    logic [LEN_W-1:0]           w_eff_len;
    logic signed [3:0]          w_img;
    logic [IDX_W-1:0]           w_ridx;
    logic                       w_match_f;
    logic                       w_match_r;

    // Saturate the loaded direction to the axis range.
    always_comb begin
        if (i_elem > 4'sd4) begin
            w_sat = 4'sd4;
        end else if (i_elem < -4'sd4) begin
            w_sat = -4'sd4;
        end else begin
            w_sat = i_elem;
        end
    end

    assign w_eff_len = r_fresh ? '0 : r_len;
    assign w_img     = lpoe_pkg::map_elem(r_base[r_k], r_mode, r_ti);
    assign w_ridx    = IDX_W'(r_len - LEN_W'(1) - LEN_W'(r_k));

    always_comb begin
        w_match_f = 1'b1;
        w_match_r = 1'b1;
        for (int i = 0; i < MAX_LEN; i++) begin
            if (LEN_W'(i) < r_len) begin
                if (r_a[i] != r_cand[i]) begin
                    w_match_f = 1'b0;
                end
                if (r_a[i] != r_rcand[i]) begin
                    w_match_r = 1'b0;
                end
            end
        end
    end

    assign o_status.len_zero = (r_len == '0);
    assign o_status.fc_full  = (r_fc >= FC_W'(MAX_PATHS));
    assign o_status.fc_zero  = (r_fc == '0);
    assign o_status.ti_end   = r_mode ? (r_ti >= lpoe_pkg::SPATIAL_COUNT)
                                      : (r_ti >= lpoe_pkg::FULL_COUNT);
    assign o_status.k_last   = (LEN_W'(r_k) == r_len - LEN_W'(1));
    assign o_status.j_last   = (FC_W'(r_j) + FC_W'(1) == r_fc);
    assign o_status.hit      = i_cmd.cmp && (w_match_f || w_match_r);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_len    <= '0;
            r_fresh  <= 1'b1;
            r_fc     <= '0;
            r_ti     <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_rd_vld <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_group_mode;
            end
            if (i_cmd.do_load) begin
                r_len   <= (w_eff_len < LEN_W'(MAX_LEN)) ? w_eff_len + LEN_W'(1) : w_eff_len;
                r_fresh <= i_last;
                r_fc    <= '0;
                r_ti    <= '0;
            end
            if (i_cmd.ti_inc) begin
                r_ti <= r_ti + 1'b1;
            end
            if (i_cmd.fc_inc) begin
                r_fc <= r_fc + 1'b1;
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.j_clr) begin
                r_j <= '0;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end
            r_rd_vld <= i_cmd.rd;
            o_strobe <= i_cmd.emit || i_cmd.put_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_load && (w_eff_len < LEN_W'(MAX_LEN))) begin
            r_base[IDX_W'(w_eff_len)] <= w_sat;
        end
        if (i_cmd.gen) begin
            r_cand[r_k]     <= w_img;
            r_rcand[w_ridx] <= 4'(-w_img);
        end
        if (r_rd_vld) begin
            r_a[r_rd_idx] <= r_rdata;
        end else if (i_cmd.cmp) begin
            // Rotate left by one within the path length.
            for (int i = 0; i < MAX_LEN; i++) begin
                if (LEN_W'(i) == r_len - LEN_W'(1)) begin
                    r_a[i] <= r_a[0];
                end else if (i < MAX_LEN - 1) begin
                    r_a[i] <= r_a[(i + 1) % MAX_LEN];
                end
            end
        end
        r_rd_idx <= r_k;
        if (i_cmd.emit) begin
            o_out_elem   <= r_cand[r_k];
            o_last_elem  <= o_status.k_last;
            o_done_res   <= 1'b0;
            o_path_index <= lpoe_pkg::PIDX_W'(r_fc);
        end else if (i_cmd.put_done) begin
            o_out_elem   <= 4'sd0;
            o_last_elem  <= 1'b1;
            o_done_res   <= 1'b1;
            o_path_index <= lpoe_pkg::PIDX_W'(r_fc);
        end
    end

    // Found-path memory: one row per stored path.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_mem[{ROW_W'(r_fc), r_k}] <= r_cand[r_k];
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[{r_j, r_k}];
        end
    end

endmodule

// File: hdl/lattice_path_orbit_enumerator_core.sv
// Top level of the lattice path orbit enumerator: controller, datapath and checks.
//
// Channel    Direction  Signals                                           Handshake
// command    in         i_func, i_elem, i_last                            start & !busy
// result     out        o_out_elem, o_last_elem, o_done_res, o_path_index o_strobe, one cycle
// config     in         i_cfg_group_mode                                  i_cfg_we
//
// A load word is taken while idle and leaves the block ready at once. A request first
// builds the candidate image, then for each stored path reads its row from the
// found-path memory and compares up to n rotations (n the path length) against the
// candidate and its reversed negation. The cost of a request thus grows with the
// transforms tried and the stored paths, set by the single read port of the memory
// and the one-rotation-per-cycle comparator; the emitted path then streams out at
// one word a cycle.
// Reset is synchronous and active low; the memory needs no clearing since only rows
// below the found count are read. The receiver cannot stall, so words leave as made.
module lattice_path_orbit_enumerator_core #(
    parameter int MAX_LEN   = lpoe_pkg::MAX_LEN_DEF,
    parameter int MAX_PATHS = lpoe_pkg::MAX_PATHS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_group_mode,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic signed [3:0]           i_elem,
    input  logic                        i_last,
    output logic                        o_strobe,
    output logic signed [3:0]           o_out_elem,
    output logic                        o_last_elem,
    output logic                        o_done_res,
    output logic [lpoe_pkg::PIDX_W-1:0] o_path_index
);

    lpoe_pkg::t_cmd    w_cmd;
    lpoe_pkg::t_status w_status;

    // The controller owns sequencing; all storage sits in the datapath.
    lpoe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    lpoe_dp #(
        .MAX_LEN   (MAX_LEN),
        .MAX_PATHS (MAX_PATHS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_group_mode (i_cfg_group_mode),
        .i_elem           (i_elem),
        .i_last           (i_last),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_strobe         (o_strobe),
        .o_out_elem       (o_out_elem),
        .o_last_elem      (o_last_elem),
        .o_done_res       (o_done_res),
        .o_path_index     (o_path_index)
    );

    // A load must never reach the datapath while a request is in flight.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_cmd.do_load)
        else $error("load issued while busy");

    // Emitting a path word and answering done are mutually exclusive.
    a_emit_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.emit && w_cmd.put_done))
        else $error("emit and done together");

    // After a done answer the block is back in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.put_done |=> !busy)
        else $error("still busy after done");

    // The final word of an emitted path bumps the found count.
    a_last_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_status.k_last) |-> w_cmd.fc_inc)
        else $error("path emitted without storing");

endmodule
